@@ rtl/wsfr_pkg.sv @@
package wsfr_pkg;

  localparam int LENGTH_BITS = 31;
  localparam int MAX_PAYLOAD_BITS = 31;
  localparam int ACC_BITS = 64;

  localparam logic [MAX_PAYLOAD_BITS-1:0] MAX_PAYLOAD_RESET = MAX_PAYLOAD_BITS'(65536);

  localparam logic [2:0] KIND_HEADER     = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD    = 3'd1;
  localparam logic [2:0] KIND_END        = 3'd2;
  localparam logic [2:0] KIND_TOO_BIG    = 3'd3;
  localparam logic [2:0] KIND_INCOMPLETE = 3'd4;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       connection_closed;
  } wsfr_in_t;

  typedef struct packed {
    logic [2:0]             result_kind;
    logic [7:0]             frame_flags;
    logic                   masked;
    logic [LENGTH_BITS-1:0] payload_length;
    logic [7:0]             payload_byte;
    logic                   last_of_frame;
  } wsfr_out_t;

endpackage

@@ rtl/websocket_frame_receiver_top.sv @@
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-------------------------------
// in       | input     | in_valid / in_ready     | in_data (wsfr_in_t)
// out      | output    | out_valid / out_ready   | out_data (wsfr_out_t)
// cfg      | input     | cfg_valid / cfg_ready   | cfg_data (max_payload, 31 bits)
//
// One byte is taken per clock unless stalled; its result, if any, appears in the
// output register on the next cycle. The parse state and the output register are
// updated in the same cycle, so the header parser sets the one-cycle item rate.
// The input stalls only while a result waits in the output register and out_ready
// is low. Reset is synchronous and returns the parser to waiting for a flags byte,
// with max_payload at 65536. The configuration port is always ready.
module websocket_frame_receiver_top
  import wsfr_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wsfr_in_t                    in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wsfr_out_t                   out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [MAX_PAYLOAD_BITS-1:0] cfg_data
);

  localparam logic [2:0] PH_FLAGS   = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_EXT16   = 3'd2;
  localparam logic [2:0] PH_EXT64   = 3'd3;
  localparam logic [2:0] PH_MASK    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  logic [MAX_PAYLOAD_BITS-1:0] max_payload;
  logic [2:0]                  phase, phase_next;
  logic [2:0]                  count, count_next;
  logic [7:0]                  flags, flags_next;
  logic                        mask_on, mask_on_next;
  logic [ACC_BITS-1:0]         acc, acc_next;
  logic [31:0]                 key, key_next;
  logic [LENGTH_BITS-1:0]      remaining, remaining_next;
  logic [1:0]                  key_idx, key_idx_next;

  wsfr_out_t res;
  logic      res_valid;
  logic      len_done;
  logic      hdr_done;
  logic      accept;
  logic [7:0] key_byte;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign key_byte  = mask_on ? key[{~key_idx, 3'b000} +: 8] : 8'd0;

  always_comb begin
    phase_next     = phase;
    count_next     = count;
    flags_next     = flags;
    mask_on_next   = mask_on;
    acc_next       = acc;
    key_next       = key;
    remaining_next = remaining;
    key_idx_next   = key_idx;
    res            = '0;
    res_valid      = 1'b0;
    len_done       = 1'b0;
    hdr_done       = 1'b0;

    if (in_data.connection_closed) begin
      res_valid = 1'b1;
      if (phase == PH_FLAGS || phase > PH_PAYLOAD) begin
        res.result_kind = KIND_END;
      end else if ((phase inside {PH_EXT16, PH_EXT64, PH_MASK}) && count == 3'd0) begin
        res.result_kind = KIND_END;
      end else begin
        res.result_kind = KIND_INCOMPLETE;
      end
      phase_next = PH_FLAGS;
      count_next = 3'd0;
    end else begin
      case (phase)
        PH_LEN: begin
          mask_on_next = in_data.stream_byte[7];
          acc_next     = '0;
          count_next   = 3'd0;
          if (in_data.stream_byte[6:0] == LEN_CODE_EXT64) begin
            phase_next = PH_EXT64;
          end else if (in_data.stream_byte[6:0] == LEN_CODE_EXT16) begin
            phase_next = PH_EXT16;
          end else begin
            acc_next = ACC_BITS'(in_data.stream_byte[6:0]);
            len_done = 1'b1;
          end
        end
        PH_EXT16, PH_EXT64: begin
          acc_next   = {acc[ACC_BITS-9:0], in_data.stream_byte};
          count_next = count + 3'd1;
          if (phase == PH_EXT16) begin
            len_done = (count_next == 3'd2);
          end else begin
            len_done = (count_next == 3'd0);
          end
        end
        PH_MASK: begin
          key_next   = {key[23:0], in_data.stream_byte};
          count_next = count + 3'd1;
          hdr_done   = (count_next == 3'd4);
        end
        PH_PAYLOAD: begin
          key_idx_next       = key_idx + 2'd1;
          remaining_next     = remaining - LENGTH_BITS'(1);
          res_valid          = 1'b1;
          res.result_kind    = KIND_PAYLOAD;
          res.frame_flags    = flags;
          res.masked         = mask_on;
          res.payload_length = acc[LENGTH_BITS-1:0];
          res.payload_byte   = in_data.stream_byte ^ key_byte;
          res.last_of_frame  = (remaining_next == '0);
          if (remaining_next == '0) begin
            phase_next = PH_FLAGS;
            count_next = 3'd0;
          end
        end
        default: begin
          flags_next   = in_data.stream_byte;
          mask_on_next = 1'b0;
          acc_next     = '0;
          key_next     = '0;
          phase_next   = PH_LEN;
          count_next   = 3'd0;
        end
      endcase

      if (len_done) begin
        if (mask_on_next) begin
          phase_next = PH_MASK;
          count_next = 3'd0;
          key_next   = '0;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        phase_next      = PH_FLAGS;
        count_next      = 3'd0;
        res_valid       = 1'b1;
        res.frame_flags = flags_next;
        res.masked      = mask_on_next;
        if (acc_next > ACC_BITS'(max_payload)) begin
          res.result_kind    = KIND_TOO_BIG;
          res.payload_length = (|acc_next[ACC_BITS-1:LENGTH_BITS]) ? '1
                                                                   : acc_next[LENGTH_BITS-1:0];
        end else if (acc_next == '0) begin
          res.result_kind   = KIND_HEADER;
          res.last_of_frame = 1'b1;
        end else begin
          res.result_kind    = KIND_HEADER;
          res.payload_length = acc_next[LENGTH_BITS-1:0];
          remaining_next     = acc_next[LENGTH_BITS-1:0];
          key_idx_next       = 2'd0;
          phase_next         = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FLAGS;
      count     <= 3'd0;
      flags     <= 8'd0;
      mask_on   <= 1'b0;
      acc       <= '0;
      key       <= '0;
      remaining <= '0;
      key_idx   <= 2'd0;
    end else if (accept) begin
      phase     <= phase_next;
      count     <= count_next;
      flags     <= flags_next;
      mask_on   <= mask_on_next;
      acc       <= acc_next;
      key       <= key_next;
      remaining <= remaining_next;
      key_idx   <= key_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_data <= res;
    end
  end

  a_idle_output_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input stalled with an empty output register.");

  a_payload_byte_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_PAYLOAD && !in_data.connection_closed
      |=> out_valid && out_data.result_kind == KIND_PAYLOAD)
    else $error("Payload byte produced no payload transaction.");

  a_payload_has_bytes_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> remaining != '0)
    else $error("Payload phase entered with no bytes remaining.");

  a_last_only_on_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_of_frame
      |-> out_data.result_kind == KIND_PAYLOAD || out_data.result_kind == KIND_HEADER)
    else $error("Last-of-frame flag on a status transaction.");

  a_close_returns_to_flags: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.connection_closed |=> phase == PH_FLAGS && count == 3'd0)
    else $error("Connection close did not reset the parser.");

endmodule
